### design/plna_pkg.sv
package plna_pkg;

  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 2;
  localparam int ADDR_W  = 24;

  localparam logic [IDX_W-1:0] REG_SPATIAL_EXTENT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_TEMPORAL_EXTENT = 2'd1;

  localparam logic [CFG_W-1:0] SPATIAL_EXTENT_RST  = 7'd8;
  localparam logic [CFG_W-1:0] TEMPORAL_EXTENT_RST = 7'd8;

endpackage

### design/periodic_lattice_neighbor_address_top.sv
// Throughput: one word per cycle; every stage holds its own valid bit, so a
// stalled output only stops the stages that are full behind it.
// Reset (rst_n low, synchronous): all valid bits clear, both extents return to 8.
module periodic_lattice_neighbor_address_top
  import plna_pkg::*;
#(
  parameter int MAX_EXTENT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  in_coord_x,
  input  logic [COORD_W-1:0]  in_coord_y,
  input  logic [COORD_W-1:0]  in_coord_z,
  input  logic [COORD_W-1:0]  in_coord_t,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_site_address,
  output logic [ADDR_W-1:0]   out_next_x,
  output logic [ADDR_W-1:0]   out_next_y,
  output logic [ADDR_W-1:0]   out_next_z,
  output logic [ADDR_W-1:0]   out_next_t,
  output logic [ADDR_W-1:0]   out_prev_x,
  output logic [ADDR_W-1:0]   out_prev_y,
  output logic [ADDR_W-1:0]   out_prev_z,
  output logic [ADDR_W-1:0]   out_prev_t,
  output logic                out_coord_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int EW     = $clog2(MAX_EXTENT + 1);
  localparam int CMP_W  = (EW > CFG_W) ? EW : CFG_W;
  localparam int PY_W   = EW + CFG_W;
  localparam int NS2_W  = 2 * EW;
  localparam int NS3_W  = (3 * EW > ADDR_W) ? ADDR_W : 3 * EW;
  localparam int PZ_W   = (NS2_W + CFG_W > ADDR_W) ? ADDR_W : NS2_W + CFG_W;
  localparam int PT_W   = (NS3_W + CFG_W > ADDR_W) ? ADDR_W : NS3_W + CFG_W;

  function automatic logic [EW-1:0] clamp_ext(input logic [CFG_W-1:0] e);
    logic [CMP_W-1:0] ec;
    logic [CMP_W-1:0] mc;
    ec = CMP_W'(e);
    mc = CMP_W'(MAX_EXTENT);
    return (ec > mc) ? EW'(mc) : EW'(ec);
  endfunction

  function automatic logic [CFG_W-1:0] wrap_up(input logic [COORD_W-1:0] c,
                                               input logic [EW-1:0] n);
    logic [CMP_W-1:0] c1;
    c1 = CMP_W'(c) + 1'b1;
    return (c1 == CMP_W'(n)) ? '0 : CFG_W'(c1);
  endfunction

  function automatic logic [CFG_W-1:0] wrap_down(input logic [COORD_W-1:0] c,
                                                 input logic [EW-1:0] n);
    return (c == '0) ? CFG_W'(n - 1'b1) : CFG_W'(c) - 1'b1;
  endfunction

  // configuration
  logic [CFG_W-1:0] spatial_extent_r, temporal_extent_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spatial_extent_r  <= SPATIAL_EXTENT_RST;
      temporal_extent_r <= TEMPORAL_EXTENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPATIAL_EXTENT:  spatial_extent_r  <= cfg_data;
        REG_TEMPORAL_EXTENT: temporal_extent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !s5_v_r || !out_stall;
  assign rdy4     = !s4_v_r || rdy5;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) s5_v_r <= s4_v_r;
    end
  end

  // stage 1: range check and wrapped coordinates
  logic [EW-1:0] ns_nxt, nt_nxt;
  logic          err_nxt;

  assign ns_nxt  = clamp_ext(spatial_extent_r);
  assign nt_nxt  = clamp_ext(temporal_extent_r);
  assign err_nxt = (CMP_W'(in_coord_x) >= CMP_W'(ns_nxt)) ||
                   (CMP_W'(in_coord_y) >= CMP_W'(ns_nxt)) ||
                   (CMP_W'(in_coord_z) >= CMP_W'(ns_nxt)) ||
                   (CMP_W'(in_coord_t) >= CMP_W'(nt_nxt));

  logic [EW-1:0]    s1_ns_r;
  logic             s1_err_r;
  logic [CFG_W-1:0] s1_x_r, s1_xu_r, s1_xd_r, s1_y_r, s1_yu_r, s1_yd_r;
  logic [CFG_W-1:0] s1_z_r, s1_zu_r, s1_zd_r, s1_t_r, s1_tu_r, s1_td_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ns_r  <= ns_nxt;
      s1_err_r <= err_nxt;
      s1_x_r   <= CFG_W'(in_coord_x);
      s1_y_r   <= CFG_W'(in_coord_y);
      s1_z_r   <= CFG_W'(in_coord_z);
      s1_t_r   <= CFG_W'(in_coord_t);
      s1_xu_r  <= wrap_up(in_coord_x, ns_nxt);
      s1_yu_r  <= wrap_up(in_coord_y, ns_nxt);
      s1_zu_r  <= wrap_up(in_coord_z, ns_nxt);
      s1_tu_r  <= wrap_up(in_coord_t, nt_nxt);
      s1_xd_r  <= wrap_down(in_coord_x, ns_nxt);
      s1_yd_r  <= wrap_down(in_coord_y, ns_nxt);
      s1_zd_r  <= wrap_down(in_coord_z, ns_nxt);
      s1_td_r  <= wrap_down(in_coord_t, nt_nxt);
    end
  end

  // stage 2: ns squared and y strides
  logic [NS2_W-1:0] ns2_nxt;
  logic [PY_W-1:0]  py_nxt, pyu_nxt, pyd_nxt;

  assign ns2_nxt = NS2_W'(s1_ns_r) * NS2_W'(s1_ns_r);
  assign py_nxt  = PY_W'(s1_ns_r) * PY_W'(s1_y_r);
  assign pyu_nxt = PY_W'(s1_ns_r) * PY_W'(s1_yu_r);
  assign pyd_nxt = PY_W'(s1_ns_r) * PY_W'(s1_yd_r);

  logic [EW-1:0]    s2_ns_r;
  logic [NS2_W-1:0] s2_ns2_r;
  logic [PY_W-1:0]  s2_py_r, s2_pyu_r, s2_pyd_r;
  logic             s2_err_r;
  logic [CFG_W-1:0] s2_x_r, s2_xu_r, s2_xd_r, s2_z_r, s2_zu_r, s2_zd_r;
  logic [CFG_W-1:0] s2_t_r, s2_tu_r, s2_td_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ns_r  <= s1_ns_r;
      s2_ns2_r <= ns2_nxt;
      s2_py_r  <= py_nxt;
      s2_pyu_r <= pyu_nxt;
      s2_pyd_r <= pyd_nxt;
      s2_err_r <= s1_err_r;
      s2_x_r   <= s1_x_r;
      s2_xu_r  <= s1_xu_r;
      s2_xd_r  <= s1_xd_r;
      s2_z_r   <= s1_z_r;
      s2_zu_r  <= s1_zu_r;
      s2_zd_r  <= s1_zd_r;
      s2_t_r   <= s1_t_r;
      s2_tu_r  <= s1_tu_r;
      s2_td_r  <= s1_td_r;
    end
  end

  // stage 3: ns cubed and z strides
  logic [NS2_W+EW-1:0]    ns3_full;
  logic [NS2_W+CFG_W-1:0] pz_full, pzu_full, pzd_full;

  assign ns3_full = (NS2_W+EW)'(s2_ns2_r) * (NS2_W+EW)'(s2_ns_r);
  assign pz_full  = (NS2_W+CFG_W)'(s2_ns2_r) * (NS2_W+CFG_W)'(s2_z_r);
  assign pzu_full = (NS2_W+CFG_W)'(s2_ns2_r) * (NS2_W+CFG_W)'(s2_zu_r);
  assign pzd_full = (NS2_W+CFG_W)'(s2_ns2_r) * (NS2_W+CFG_W)'(s2_zd_r);

  logic [NS3_W-1:0] s3_ns3_r;
  logic [PZ_W-1:0]  s3_pz_r, s3_pzu_r, s3_pzd_r;
  logic [PY_W-1:0]  s3_py_r, s3_pyu_r, s3_pyd_r;
  logic             s3_err_r;
  logic [CFG_W-1:0] s3_x_r, s3_xu_r, s3_xd_r, s3_t_r, s3_tu_r, s3_td_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ns3_r <= NS3_W'(ns3_full);
      s3_pz_r  <= PZ_W'(pz_full);
      s3_pzu_r <= PZ_W'(pzu_full);
      s3_pzd_r <= PZ_W'(pzd_full);
      s3_py_r  <= s2_py_r;
      s3_pyu_r <= s2_pyu_r;
      s3_pyd_r <= s2_pyd_r;
      s3_err_r <= s2_err_r;
      s3_x_r   <= s2_x_r;
      s3_xu_r  <= s2_xu_r;
      s3_xd_r  <= s2_xd_r;
      s3_t_r   <= s2_t_r;
      s3_tu_r  <= s2_tu_r;
      s3_td_r  <= s2_td_r;
    end
  end

  // stage 4: t strides and partial sums over x, y, z
  logic [NS3_W+CFG_W-1:0] pt_full, ptu_full, ptd_full;
  logic [ADDR_W-1:0]      ax, ay, az, ayu, ayd, azu, azd;

  assign pt_full  = (NS3_W+CFG_W)'(s3_ns3_r) * (NS3_W+CFG_W)'(s3_t_r);
  assign ptu_full = (NS3_W+CFG_W)'(s3_ns3_r) * (NS3_W+CFG_W)'(s3_tu_r);
  assign ptd_full = (NS3_W+CFG_W)'(s3_ns3_r) * (NS3_W+CFG_W)'(s3_td_r);
  assign ax       = ADDR_W'(s3_x_r);
  assign ay       = ADDR_W'(s3_py_r);
  assign az       = ADDR_W'(s3_pz_r);
  assign ayu      = ADDR_W'(s3_pyu_r);
  assign ayd      = ADDR_W'(s3_pyd_r);
  assign azu      = ADDR_W'(s3_pzu_r);
  assign azd      = ADDR_W'(s3_pzd_r);

  logic [ADDR_W-1:0] s4_pt_r, s4_ptu_r, s4_ptd_r;
  logic [ADDR_W-1:0] s4_q_r, s4_qxu_r, s4_qxd_r, s4_qyu_r, s4_qyd_r, s4_qzu_r, s4_qzd_r;
  logic              s4_err_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_pt_r  <= ADDR_W'(PT_W'(pt_full));
      s4_ptu_r <= ADDR_W'(PT_W'(ptu_full));
      s4_ptd_r <= ADDR_W'(PT_W'(ptd_full));
      s4_q_r   <= ax + ay + az;
      s4_qxu_r <= ADDR_W'(s3_xu_r) + ay + az;
      s4_qxd_r <= ADDR_W'(s3_xd_r) + ay + az;
      s4_qyu_r <= ax + ayu + az;
      s4_qyd_r <= ax + ayd + az;
      s4_qzu_r <= ax + ay + azu;
      s4_qzd_r <= ax + ay + azd;
      s4_err_r <= s3_err_r;
    end
  end

  // stage 5: final sums, zeroed on error
  logic [ADDR_W-1:0] site_r, next_x_r, next_y_r, next_z_r, next_t_r;
  logic [ADDR_W-1:0] prev_x_r, prev_y_r, prev_z_r, prev_t_r;
  logic              err_r;
  logic [ADDR_W-1:0] keep;

  assign keep = {ADDR_W{!s4_err_r}};

  always_ff @(posedge clk) begin
    if (rdy5) begin
      site_r   <= keep & (s4_q_r   + s4_pt_r);
      next_x_r <= keep & (s4_qxu_r + s4_pt_r);
      next_y_r <= keep & (s4_qyu_r + s4_pt_r);
      next_z_r <= keep & (s4_qzu_r + s4_pt_r);
      next_t_r <= keep & (s4_q_r   + s4_ptu_r);
      prev_x_r <= keep & (s4_qxd_r + s4_pt_r);
      prev_y_r <= keep & (s4_qyd_r + s4_pt_r);
      prev_z_r <= keep & (s4_qzd_r + s4_pt_r);
      prev_t_r <= keep & (s4_q_r   + s4_ptd_r);
      err_r    <= s4_err_r;
    end
  end

  assign out_valid        = s5_v_r;
  assign out_site_address = site_r;
  assign out_next_x       = next_x_r;
  assign out_next_y       = next_y_r;
  assign out_next_z       = next_z_r;
  assign out_next_t       = next_t_r;
  assign out_prev_x       = prev_x_r;
  assign out_prev_y       = prev_y_r;
  assign out_prev_z       = prev_z_r;
  assign out_prev_t       = prev_t_r;
  assign out_coord_error  = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coord_error) |->
      (out_site_address == '0 && out_next_x == '0 && out_next_t == '0 &&
       out_prev_x == '0 && out_prev_t == '0))
    else $error("error word carries a non-zero address");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_v_r && !s4_v_r))
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s5_v_r && out_stall) |=> s4_v_r)
    else $error("word lost behind a stalled output");

  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && s5_v_r))
    else $error("input stalled with a free stage");

endmodule

### tb/periodic_lattice_neighbor_address_top_tb.sv
module periodic_lattice_neighbor_address_top_tb;
  import plna_pkg::*;

  localparam int MAX_EXTENT = 64;
  localparam int LATENCY    = 5;
  localparam int QUIET_MAX  = 4000;
  localparam int PHASES     = 14;
  localparam int PHASE_SITES = 125;

  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] site;
    logic [ADDR_W-1:0] next_x;
    logic [ADDR_W-1:0] next_y;
    logic [ADDR_W-1:0] next_z;
    logic [ADDR_W-1:0] next_t;
    logic [ADDR_W-1:0] prev_x;
    logic [ADDR_W-1:0] prev_y;
    logic [ADDR_W-1:0] prev_z;
    logic [ADDR_W-1:0] prev_t;
    logic              coord_error;
  } neighbor_set_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [COORD_W-1:0] in_coord_x;
  logic [COORD_W-1:0] in_coord_y;
  logic [COORD_W-1:0] in_coord_z;
  logic [COORD_W-1:0] in_coord_t;
  logic               out_valid;
  logic               out_stall;
  logic [ADDR_W-1:0]  out_site_address;
  logic [ADDR_W-1:0]  out_next_x;
  logic [ADDR_W-1:0]  out_next_y;
  logic [ADDR_W-1:0]  out_next_z;
  logic [ADDR_W-1:0]  out_next_t;
  logic [ADDR_W-1:0]  out_prev_x;
  logic [ADDR_W-1:0]  out_prev_y;
  logic [ADDR_W-1:0]  out_prev_z;
  logic [ADDR_W-1:0]  out_prev_t;
  logic               out_coord_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  logic [CFG_W-1:0]   spatial_ext;
  logic [CFG_W-1:0]   temporal_ext;
  neighbor_set_t      awaited_sets[$];

  bit                 in_gaps;
  bit                 out_stalls;
  int                 failures;
  int                 shown;
  int                 sites_sent;
  int                 error_sites;
  int                 settings_used;

  periodic_lattice_neighbor_address_top #(
    .MAX_EXTENT(MAX_EXTENT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_coord_t       (in_coord_t),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_site_address (out_site_address),
    .out_next_x       (out_next_x),
    .out_next_y       (out_next_y),
    .out_next_z       (out_next_z),
    .out_next_t       (out_next_t),
    .out_prev_x       (out_prev_x),
    .out_prev_y       (out_prev_y),
    .out_prev_z       (out_prev_z),
    .out_prev_t       (out_prev_t),
    .out_coord_error  (out_coord_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_extent(input logic [CFG_W-1:0] ext);
    return (ext > MAX_EXTENT) ? MAX_EXTENT : ext;
  endfunction

  function automatic int unsigned step_up(input int unsigned c, input int unsigned ext);
    return (c + 1 == ext) ? 0 : c + 1;
  endfunction

  function automatic int unsigned step_down(input int unsigned c, input int unsigned ext);
    return (c == 0) ? ext - 1 : c - 1;
  endfunction

  function automatic logic [ADDR_W-1:0] lattice_addr(input int unsigned x, input int unsigned y,
                                                     input int unsigned z, input int unsigned t,
                                                     input int unsigned ns);
    int unsigned full;
    full = x + ns * (y + ns * (z + ns * t));
    return full[ADDR_W-1:0];
  endfunction

  function automatic neighbor_set_t lattice_neighbors(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      input logic [COORD_W-1:0] z,
                                                      input logic [COORD_W-1:0] t);
    int unsigned   ns;
    int unsigned   nt;
    neighbor_set_t r;
    ns = clamp_extent(spatial_ext);
    nt = clamp_extent(temporal_ext);
    r  = '0;
    if (x >= ns || y >= ns || z >= ns || t >= nt) begin
      r.coord_error = 1'b1;
      return r;
    end
    r.site   = lattice_addr(x, y, z, t, ns);
    r.next_x = lattice_addr(step_up(x, ns), y, z, t, ns);
    r.next_y = lattice_addr(x, step_up(y, ns), z, t, ns);
    r.next_z = lattice_addr(x, y, step_up(z, ns), t, ns);
    r.next_t = lattice_addr(x, y, z, step_up(t, nt), ns);
    r.prev_x = lattice_addr(step_down(x, ns), y, z, t, ns);
    r.prev_y = lattice_addr(x, step_down(y, ns), z, t, ns);
    r.prev_z = lattice_addr(x, y, step_down(z, ns), t, ns);
    r.prev_t = lattice_addr(x, y, z, step_down(t, nt), ns);
    return r;
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned ext);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (ext == 0 || r < 10) return COORD_W'($urandom_range(0, 63));
    if (r < 20) return '0;
    if (r < 30) return COORD_W'(ext - 1);
    return COORD_W'($urandom_range(0, ext - 1));
  endfunction

  task automatic send_site(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] t);
    int            gap;
    neighbor_set_t want;
    gap = 0;
    if (in_gaps && $urandom_range(0, 99) >= 60) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_coord_t <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = lattice_neighbors(x, y, z, t);
    awaited_sets.push_back(want);
    sites_sent++;
    if (want.coord_error) error_sites++;
    @(negedge clk);
  endtask

  task automatic send_random_site();
    int unsigned ns;
    int unsigned nt;
    ns = clamp_extent(spatial_ext);
    nt = clamp_extent(temporal_ext);
    send_site(pick_coord(ns), pick_coord(ns), pick_coord(ns), pick_coord(nt));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (awaited_sets.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // leave cfg_valid high; the caller drops it after the last word
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPATIAL_EXTENT:  spatial_ext  = value;
      REG_TEMPORAL_EXTENT: temporal_ext = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_extents(input logic [CFG_W-1:0] ns, input logic [CFG_W-1:0] nt);
    drain_pipeline();
    write_reg(REG_SPATIAL_EXTENT, ns);
    write_reg(REG_TEMPORAL_EXTENT, nt);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic compare_word(input string label, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      failures++;
      if (shown < 10) begin
        shown++;
        $display("mismatch on %s at %0t: expected %0d, got %0d", label, $time, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    neighbor_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_sets.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word at %0t: site address %0d", $time,
                   out_site_address);
        end
      end else begin
        want = awaited_sets.pop_front();
        compare_word("site_address", want.site, out_site_address);
        compare_word("next_x", want.next_x, out_next_x);
        compare_word("next_y", want.next_y, out_next_y);
        compare_word("next_z", want.next_z, out_next_z);
        compare_word("next_t", want.next_t, out_next_t);
        compare_word("prev_x", want.prev_x, out_prev_x);
        compare_word("prev_y", want.prev_y, out_prev_y);
        compare_word("prev_z", want.prev_z, out_prev_z);
        compare_word("prev_t", want.prev_t, out_prev_t);
        compare_word("coord_error", ADDR_W'(want.coord_error), ADDR_W'(out_coord_error));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (out_stalls) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic test_reset_extents();
    send_site(6'd0, 6'd0, 6'd0, 6'd0);
    send_site(6'd7, 6'd7, 6'd7, 6'd7);
    send_site(6'd0, 6'd7, 6'd3, 6'd5);
    send_site(6'd8, 6'd0, 6'd0, 6'd0);
    send_site(6'd0, 6'd0, 6'd0, 6'd8);
    send_site(6'd63, 6'd63, 6'd63, 6'd63);
  endtask

  task automatic test_unit_extents();
    program_extents(7'd1, 7'd1);
    send_site(6'd0, 6'd0, 6'd0, 6'd0);
    send_site(6'd1, 6'd0, 6'd0, 6'd0);
    program_extents(7'd2, 7'd1);
    send_site(6'd1, 6'd0, 6'd1, 6'd0);
    send_site(6'd1, 6'd1, 6'd1, 6'd1);
  endtask

  task automatic test_zero_extents();
    program_extents(7'd0, 7'd8);
    send_site(6'd0, 6'd0, 6'd0, 6'd0);
    program_extents(7'd4, 7'd0);
    send_site(6'd0, 6'd0, 6'd0, 6'd0);
    send_site(6'd3, 6'd2, 6'd1, 6'd0);
  endtask

  task automatic test_saturated_extents();
    program_extents(7'd127, 7'd65);
    send_site(6'd63, 6'd63, 6'd63, 6'd63);
    send_site(6'd0, 6'd0, 6'd0, 6'd0);
    program_extents(7'd64, 7'd64);
    send_site(6'd63, 6'd0, 6'd63, 6'd0);
    send_site(6'd42, 6'd21, 6'd42, 6'd21);
  endtask

  task automatic test_spare_indexes();
    program_extents(7'd5, 7'd3);
    @(negedge clk);
    write_reg(REG_SPARE_2, 7'd1);
    write_reg(REG_SPARE_3, 7'd127);
    cfg_valid <= 1'b0;
    send_site(6'd4, 6'd4, 6'd4, 6'd2);
    send_site(6'd0, 6'd0, 6'd0, 6'd3);
  endtask

  task automatic test_random_sweeps();
    logic [CFG_W-1:0] ns_list[8];
    logic [CFG_W-1:0] nt_list[8];
    logic [CFG_W-1:0] ns;
    logic [CFG_W-1:0] nt;
    ns_list = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd2, 7'd64, 7'd65};
    nt_list = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd64, 7'd1, 7'd3};
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        ns = ns_list[p];
        nt = nt_list[p];
      end else begin
        ns = ($urandom_range(0, 99) < 15) ? CFG_W'($urandom_range(65, 127))
                                          : CFG_W'($urandom_range(1, 64));
        nt = ($urandom_range(0, 99) < 15) ? CFG_W'($urandom_range(65, 127))
                                          : CFG_W'($urandom_range(1, 64));
      end
      program_extents(ns, nt);
      in_gaps    = p[0];
      out_stalls = p[1];
      for (int k = 0; k < PHASE_SITES; k++) begin
        // hold the sender until the pipeline has emptied
        if (p == 3 && k == PHASE_SITES / 2) drain_pipeline();
        send_random_site();
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_coord_x   = '0;
    in_coord_y   = '0;
    in_coord_z   = '0;
    in_coord_t   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SPATIAL_EXTENT;
    cfg_data     = '0;
    spatial_ext  = SPATIAL_EXTENT_RST;
    temporal_ext = TEMPORAL_EXTENT_RST;
    in_gaps      = 1'b1;
    out_stalls   = 1'b1;
    failures     = 0;
    shown        = 0;
    sites_sent   = 0;
    error_sites  = 0;
    settings_used = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_extents();
    test_unit_extents();
    test_zero_extents();
    test_saturated_extents();
    test_spare_indexes();
    test_random_sweeps();

    drain_pipeline();
    if (awaited_sets.size() != 0) failures++;
    $display("Checked %0d sites over %0d extent settings, %0d of them out of range.",
             sites_sent, settings_used, error_sites);
    $display("Extents covered zero, one, full and saturated values; %0d mismatches.",
             failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/plna_pkg.sv
design/periodic_lattice_neighbor_address_top.sv
tb/periodic_lattice_neighbor_address_top_tb.sv
